@@ design/swrl_pkg.sv @@
`timescale 1ns / 1ps

package swrl_pkg;

  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned IN_TIME_W = 48;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned MUL_A_W  = CNT_W + 1;
  localparam int unsigned PROD_W   = MUL_A_W + LEN_W;
  localparam int unsigned ACC_W    = PROD_W + 1;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned M_TDATA_W  = 24;

  localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = 32'd60;
  localparam logic [CNT_W-1:0] REQUEST_LIMIT_RST = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 8'd0,
    CFG_REQUEST_LIMIT = 8'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CMP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic ge2;
  } div_stat_t;

endpackage

@@ design/swrl_div.sv @@
`timescale 1ns / 1ps

module swrl_div import swrl_pkg::*; #(
  parameter int unsigned TW = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TW-1:0]    dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output logic [LEN_W-1:0] rem_o,
  output div_stat_t        stat_o
);

  localparam int unsigned CW = $clog2(TW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [TW-1:0]    quo_q, quo_d;
  logic [LEN_W-1:0] dvs_q, dvs_d;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             take;

  // one quotient bit a cycle, dividend shifts out of the quotient register
  always_comb begin
    trial = {rem_q, quo_q[TW-1]};
    diff  = trial - {1'b0, dvs_q};
    take  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CW'(TW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = take ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_d = {quo_q[TW-2:0], take};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(0)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.ge2  = |quo_q[TW-1:1];

endmodule

@@ design/swrl_mul.sv @@
`timescale 1ns / 1ps

module swrl_mul import swrl_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [LEN_W-1:0]   b_i,
  output logic [PROD_W-1:0]  p_o
);

  logic [PROD_W-1:0] p_q, p_d;

  // product is registered: it lands in the cycle after the operands
  always_comb begin
    p_d = PROD_W'(a_i) * PROD_W'(b_i);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ design/sliding_window_rate_limiter.sv @@
`timescale 1ns / 1ps

// Sliding-window-counter rate limiter over a table of USER_SLOTS users. A request carries a
// user slot and a timestamp and yields one result: allowed and the slot's current-window count.
// After reset the valid bits of the table are swept clear, one entry a cycle, during which no
// request is taken (configuration writes still are). The block then works on one request at
// a time: a request that falls in the slot's current window goes through lookup, check, the
// three multiplies, compare and response, and one that has to roll the window over first runs
// the restoring divider, which yields one quotient bit a cycle. The result waits in the response
// state while an earlier result still holds the output register, and the next request is taken
// in the cycle the result appears.
// The admission test uses one registered 17x32 multiplier three times in a row. A request can
// be accepted while the previous result still waits on the output register. A zero window
// length is taken as one; a slot beyond the table is rejected with a count of zero.

module sliding_window_rate_limiter import swrl_pkg::*; #(
  parameter int unsigned USER_SLOTS = 64,
  parameter int unsigned TIME_BITS  = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // user_slot [5:0], request_time [53:6], zero [55:54]
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // allowed [0], window_count [16:1], zero [23:17]
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned AW = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;

  state_e state_q, state_d;

  logic [LEN_W-1:0] wlen_q;
  logic [CNT_W-1:0] limit_q;
  logic [LEN_W-1:0] w_eff;

  logic [SLOT_W-1:0]        in_slot;
  logic [IN_TIME_W-1:0]     in_time;
  logic [TW+IN_TIME_W-1:0]  time_ext;
  logic [AW+SLOT_W-1:0]     addr_ext;
  logic [AW-1:0]            in_addr;
  logic                     in_slot_ok;
  logic                     in_fire;

  // table
  logic             valid_mem [USER_SLOTS];
  logic [TW-1:0]    start_mem [USER_SLOTS];
  logic [CNT_W-1:0] cur_mem   [USER_SLOTS];
  logic [CNT_W-1:0] prev_mem  [USER_SLOTS];
  logic             valid_rd_q;
  logic [TW-1:0]    start_rd_q;
  logic [CNT_W-1:0] cur_rd_q;
  logic [CNT_W-1:0] prev_rd_q;

  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    addr_q;
  logic [TW-1:0]    time_q;
  logic [TW-1:0]    start_q;
  logic [CNT_W-1:0] cur_q;
  logic [CNT_W-1:0] prev_q;
  logic [TW-1:0]    elapsed_q;
  logic [ACC_W-1:0] acc_q;
  logic             res_allowed_q;
  logic [CNT_W-1:0] res_count_q;
  logic             out_allowed_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_valid_q, out_valid_d;

  logic [TW-1:0]       lk_start;
  logic [TW+32-1:0]    el_ext;
  logic [LEN_W-1:0]    el_low;
  logic [TW+LEN_W-1:0] rem_ext;
  logic [TW-1:0]       rem_tw;
  logic                need_roll;
  logic                ok;
  logic [CNT_W-1:0]    cur_new;

  // sequencer outputs
  logic               rd_en;
  logic               wr_en;
  logic               clr_en;
  logic               div_start;
  logic               load_out;
  logic [MUL_A_W-1:0] mul_a;
  logic [LEN_W-1:0]   mul_b;

  logic [LEN_W-1:0]  div_rem;
  div_stat_t         div_stat;
  logic [PROD_W-1:0] prod;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q  <= WINDOW_LENGTH_RST;
      limit_q <= REQUEST_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WINDOW_LENGTH: wlen_q  <= cfg_data_i[LEN_W-1:0];
        CFG_REQUEST_LIMIT: limit_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (wlen_q == '0) ? LEN_W'(1) : wlen_q;

  assign in_slot    = s_axis_tdata[SLOT_W-1:0];
  assign in_time    = s_axis_tdata[SLOT_W+IN_TIME_W-1:SLOT_W];
  assign time_ext   = {{TW{1'b0}}, in_time};
  assign addr_ext   = {{AW{1'b0}}, in_slot};
  assign in_addr    = addr_ext[AW-1:0];
  assign in_slot_ok = (32'(in_slot) < USER_SLOTS);
  assign in_fire    = s_axis_tvalid && s_axis_tready;

  // working values
  always_comb begin
    lk_start  = valid_rd_q ? start_rd_q : time_q;
    el_ext    = {32'b0, elapsed_q};
    el_low    = el_ext[LEN_W-1:0];
    rem_ext   = {{TW{1'b0}}, div_rem};
    rem_tw    = rem_ext[TW-1:0];
    need_roll = ({{LEN_W{1'b0}}, elapsed_q} >= {{TW{1'b0}}, w_eff});
    ok        = (acc_q <= {1'b0, prod});
    cur_new   = ok ? (cur_q + CNT_W'(1)) : cur_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == AW'(USER_SLOTS - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (s_axis_tvalid) state_d = in_slot_ok ? ST_LOOKUP : ST_RESP;
      ST_LOOKUP: state_d = ST_CHECK;
      ST_CHECK:  state_d = need_roll ? ST_DIV : ST_MUL1;
      ST_DIV:    if (div_stat.done) state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_MUL3;
      ST_MUL3:   state_d = ST_CMP;
      ST_CMP:    state_d = ST_RESP;
      ST_RESP:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    clr_en        = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_q)
      ST_CLEAR: clr_en = 1'b1;
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_en         = s_axis_tvalid && in_slot_ok;
      end
      ST_CHECK: div_start = need_roll;
      ST_MUL1: begin
        mul_a = {1'b0, cur_q} + MUL_A_W'(1);
        mul_b = w_eff;
      end
      ST_MUL2: begin
        mul_a = {1'b0, prev_q};
        mul_b = w_eff - el_low;
      end
      ST_MUL3: begin
        mul_a = {1'b0, limit_q};
        mul_b = w_eff;
      end
      ST_CMP:  wr_en = 1'b1;
      ST_RESP: load_out = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign clr_d       = clr_en ? (clr_q + AW'(1)) : clr_q;
  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (clr_en) begin
      valid_mem[clr_q] <= 1'b0;
    end else if (wr_en) begin
      valid_mem[addr_q] <= 1'b1;
    end
    if (wr_en) begin
      start_mem[addr_q] <= start_q;
      cur_mem[addr_q]   <= cur_new;
      prev_mem[addr_q]  <= prev_q;
    end
    if (rd_en) begin
      valid_rd_q <= valid_mem[in_addr];
      start_rd_q <= start_mem[in_addr];
      cur_rd_q   <= cur_mem[in_addr];
      prev_rd_q  <= prev_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          addr_q        <= in_addr;
          time_q        <= time_ext[TW-1:0];
          res_allowed_q <= 1'b0;
          res_count_q   <= '0;
        end
      end
      ST_LOOKUP: begin
        // a fresh slot opens its window at the request time
        start_q   <= lk_start;
        cur_q     <= valid_rd_q ? cur_rd_q : '0;
        prev_q    <= valid_rd_q ? prev_rd_q : '0;
        elapsed_q <= (time_q >= lk_start) ? (time_q - lk_start) : '0;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          // start + passed*w is the request time less the remainder
          start_q   <= time_q - rem_tw;
          prev_q    <= div_stat.ge2 ? '0 : cur_q;
          cur_q     <= '0;
          elapsed_q <= rem_tw;
        end
      end
      ST_MUL2: acc_q <= ACC_W'(prod);
      ST_MUL3: acc_q <= acc_q + ACC_W'(prod);
      ST_CMP: begin
        res_allowed_q <= ok;
        res_count_q   <= cur_new;
      end
      default: ;
    endcase
    if (load_out) begin
      out_allowed_q <= res_allowed_q;
      out_count_q   <= res_count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - CNT_W - 1){1'b0}}, out_count_q, out_allowed_q};

  swrl_div #(
    .TW(TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed_q),
    .divisor_i  (w_eff),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  swrl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // an admitted request never takes the count past the limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && ok) |-> ({1'b0, cur_q} + 17'd1 <= {1'b0, limit_q}))
    else $error("admitted request exceeds limit");

  // the reduced elapsed time lies inside one window
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_stat.done) |-> (div_rem < w_eff))
    else $error("divider remainder not below window length");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_RESP)
    else $error("result raised outside response state");

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!rd_en && !wr_en))
    else $error("table access during clearing pass");

endmodule

@@ bench/sliding_window_rate_limiter_tb.sv @@
`timescale 1ns / 1ps

module sliding_window_rate_limiter_tb;
  import swrl_pkg::*;

  localparam int unsigned SLOTS         = 64;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 240;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned MAX_PRINTS    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_CHOKE} rx_mode_e;

  typedef struct packed {
    logic             allowed;
    logic [CNT_W-1:0] count;
  } verdict_t;

  typedef struct {
    row_kind_e             kind;
    logic [SLOT_W-1:0]     slot;
    logic [IN_TIME_W-1:0]  stamp;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  has_exp;
    verdict_t              exp;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // limiter state as the testbench sees it
  logic [LEN_W-1:0]     cfg_len   = WINDOW_LENGTH_RST;
  logic [CNT_W-1:0]     cfg_limit = REQUEST_LIMIT_RST;
  logic                 slot_live  [SLOTS];
  logic [IN_TIME_W-1:0] slot_start [SLOTS];
  logic [CNT_W-1:0]     slot_cur   [SLOTS];
  logic [CNT_W-1:0]     slot_prev  [SLOTS];

  verdict_t pending_verdicts[$];
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned admitted = 0;
  int unsigned rejected = 0;
  int unsigned rollovers = 0;
  int unsigned settings = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_mode_left = 0;

  sliding_window_rate_limiter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] eff_window(input logic [LEN_W-1:0] len);
    return (len == '0) ? 64'd1 : 64'(len);
  endfunction

  // admission decision for one request, updating the slot entry
  function automatic verdict_t admit_request(input logic [SLOT_W-1:0] slot,
                                             input logic [IN_TIME_W-1:0] stamp);
    logic [63:0] w;
    logic [63:0] elapsed;
    logic [63:0] passed;
    logic [63:0] lhs;
    logic [63:0] rhs;
    verdict_t    v;
    w = eff_window(cfg_len);
    if (!slot_live[slot]) begin
      slot_live[slot]  = 1'b1;
      slot_start[slot] = stamp;
      slot_cur[slot]   = '0;
      slot_prev[slot]  = '0;
    end
    // an earlier timestamp sits at the window start
    elapsed = (stamp >= slot_start[slot]) ? 64'(stamp - slot_start[slot]) : 64'd0;
    if (elapsed >= w) begin
      passed = elapsed / w;
      slot_start[slot] = slot_start[slot] + IN_TIME_W'(passed * w);
      slot_prev[slot]  = (passed >= 64'd2) ? '0 : slot_cur[slot];
      slot_cur[slot]   = '0;
      elapsed = elapsed - passed * w;
      rollovers++;
    end
    lhs = (64'(slot_cur[slot]) + 64'd1) * w + 64'(slot_prev[slot]) * (w - elapsed);
    rhs = 64'(cfg_limit) * w;
    v.allowed = (lhs <= rhs);
    if (v.allowed) begin
      slot_cur[slot] = slot_cur[slot] + 1'b1;
    end
    v.count = slot_cur[slot];
    return v;
  endfunction

  // mostly small steps inside a window, some rollovers, jumps and backward steps
  function automatic logic [IN_TIME_W-1:0] next_stamp(input logic [IN_TIME_W-1:0] last,
                                                      input logic [63:0] w);
    logic [63:0] r;
    int unsigned pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 60) return last + IN_TIME_W'(r % (w / 8 + 1));
    if (pick < 75) return last + IN_TIME_W'(w - w / 16 + r % (w / 8 + 1));
    if (pick < 85) return last + IN_TIME_W'(w * $urandom_range(2, 5) + r % w);
    if (pick < 90) return last + r[IN_TIME_W-1:0];
    if (pick < 95) return last - IN_TIME_W'(r % (w / 4 + 1));
    return r[IN_TIME_W-1:0];
  endfunction

  function automatic plan_row_t req_row(input logic [SLOT_W-1:0] slot,
                                        input logic [IN_TIME_W-1:0] stamp);
    plan_row_t row;
    row = '{ROW_REQ, slot, stamp, '0, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t chk_row(input logic [SLOT_W-1:0] slot,
                                        input logic [IN_TIME_W-1:0] stamp,
                                        input logic allowed, input logic [CNT_W-1:0] count);
    plan_row_t row;
    row = '{ROW_REQ, slot, stamp, '0, '0, 1'b1, '{allowed, count}};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{ROW_CFG, '0, '0, idx, data, 1'b0, '0};
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    end
    error_count++;
  endtask

  // valid stays high after the handshake; the next request or a gap takes over
  task automatic send_request(input logic [SLOT_W-1:0] slot,
                              input logic [IN_TIME_W-1:0] stamp,
                              input logic has_exp, input verdict_t exp);
    verdict_t v;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({stamp, slot});
    do @(posedge clk_i); while (!s_axis_tready);
    v = admit_request(slot, stamp);
    pending_verdicts.push_back(has_exp ? exp : v);
    requests_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input logic last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) begin
      cfg_valid_i <= 1'b0;
    end
    if (idx == CFG_WINDOW_LENGTH) begin
      cfg_len = data[LEN_W-1:0];
    end else if (idx == CFG_REQUEST_LIMIT) begin
      cfg_limit = data[CNT_W-1:0];
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no request outstanding", 64'(m_axis_tdata), 64'd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.allowed) begin
          report_mismatch("allowed", 64'(m_axis_tdata[0]), 64'(want.allowed));
        end
        if (m_axis_tdata[CNT_W:1] !== want.count) begin
          report_mismatch("window_count", 64'(m_axis_tdata[CNT_W:1]), 64'(want.count));
        end
        if (m_axis_tdata[0]) begin
          admitted++;
        end else begin
          rejected++;
        end
      end
    end
  end

  // receiver back-pressure, switching between patterns
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_FREE:  m_axis_tready <= 1'b1;
      RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_axis_tready <= ($urandom_range(0, 5) == 0);
      default:  m_axis_tready <= ($urandom_range(0, 39) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t             plan[$];
    logic [IN_TIME_W-1:0]  last_stamp [SLOTS];
    logic [SLOT_W-1:0]     hot [4];
    logic [SLOT_W-1:0]     slot;
    logic [IN_TIME_W-1:0]  stamp;
    logic [LEN_W-1:0]      len;
    logic [CFG_DATA_W-1:0] lim;
    logic [63:0]           w;
    logic                  last;
    int unsigned           gap_max;
    int unsigned           burst;
    int unsigned           sent;

    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i]  = 1'b0;
      slot_start[i] = '0;
      slot_cur[i]   = '0;
      slot_prev[i]  = '0;
      last_stamp[i] = (i % 2 == 0) ? IN_TIME_W'($urandom_range(0, 1000))
                                   : IN_TIME_W'({$urandom, $urandom});
    end

    // reset values: window 60, limit 10
    plan.push_back(chk_row(6'd0, 48'd0, 1'b1, 16'd1));
    plan.push_back(chk_row(6'd63, 48'hFFFF_FFFF_FFFF, 1'b1, 16'd1));
    plan.push_back(chk_row(6'd0, 48'd30, 1'b1, 16'd2));
    plan.push_back(req_row(6'd0, 48'd60));   // one window on
    plan.push_back(req_row(6'd0, 48'd20));   // earlier than the window start
    plan.push_back(req_row(6'd0, 48'd300));  // several windows on
    plan.push_back(cfg_row(CFG_REQUEST_LIMIT, 32'd0));
    plan.push_back(chk_row(6'd1, 48'd5, 1'b0, 16'd0));
    plan.push_back(cfg_row(CFG_REQUEST_LIMIT, 32'd2));
    plan.push_back(chk_row(6'd2, 48'd7, 1'b1, 16'd1));
    plan.push_back(chk_row(6'd2, 48'd7, 1'b1, 16'd2));
    plan.push_back(chk_row(6'd2, 48'd7, 1'b0, 16'd2));
    plan.push_back(cfg_row(CFG_WINDOW_LENGTH, 32'd0));  // zero length acts as one
    plan.push_back(req_row(6'd2, 48'd8));
    plan.push_back(req_row(6'd2, 48'd10));
    plan.push_back(cfg_row(CFG_WINDOW_LENGTH, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(CFG_REQUEST_LIMIT, 32'hFFFF_FFFF));
    plan.push_back(chk_row(6'd42, 48'h8000_0000_0000, 1'b1, 16'd1));
    plan.push_back(req_row(6'd42, 48'h8000_FFFF_FFFF));
    plan.push_back(cfg_row(CFG_UNUSED, 32'h5A5A_A5A5));
    plan.push_back(chk_row(6'd21, 48'h5555_5555_5555, 1'b1, 16'd1));
    plan.push_back(cfg_row(CFG_WINDOW_LENGTH, 32'd60));
    plan.push_back(cfg_row(CFG_REQUEST_LIMIT, 32'd10));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        last = (i + 1 == plan.size()) || (plan[i+1].kind != ROW_CFG);
        write_reg(plan[i].reg_idx, plan[i].reg_data, last);
        settings++;
      end else begin
        send_request(plan[i].slot, plan[i].stamp, plan[i].has_exp, plan[i].exp);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin len = 32'd60;        lim = 32'd10;        end
        1:       begin len = 32'd1;         lim = 32'd1;         end
        2:       begin len = 32'd0;         lim = 32'd4;         end
        3:       begin len = 32'hFFFF_FFFF; lim = 32'h0000_FFFF; end
        4:       begin len = 32'd1000;      lim = 32'd0;         end
        5:       begin len = $urandom_range(2, 300); lim = $urandom_range(1, 25); end
        6:       begin len = $urandom;      lim = $urandom;      end
        default: begin len = 32'd16;        lim = 32'hABCD_0003; end
      endcase
      drain_results();
      write_reg(CFG_WINDOW_LENGTH, len, 1'b0);
      write_reg(CFG_REQUEST_LIMIT, lim, 1'b1);
      settings += 2;
      w = eff_window(len);
      for (int h = 0; h < 4; h++) begin
        hot[h] = SLOT_W'($urandom_range(0, SLOTS - 1));
      end
      // every third phase the sender adds no random gaps and pauses only to drain results
      gap_max = (phase % 3 == 0) ? 0 : 8;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
          slot = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)]
                                             : SLOT_W'($urandom_range(0, SLOTS - 1));
          stamp = next_stamp(last_stamp[slot], w);
          last_stamp[slot] = stamp;
          send_request(slot, stamp, 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end else if (gap_max != 0 && $urandom_range(0, 3) != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d requests over 64 slots: %0d admitted, %0d rejected, %0d window rollovers",
             requests_sent, admitted, rejected, rollovers);
    $display("%0d register writes, window length 0 to full scale, limit 0 to full scale",
             settings);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
